// File: hdl/lav_pkg.sv
package lav_pkg;

  // Normalizer datapath sizes
  localparam int NW        = 36;   // normalizer input, signed
  localparam int OW        = 18;   // unit vector component, signed, up to +/-1.0
  localparam int MW        = 30;   // scaled magnitude
  localparam int SQ_STEPS  = 31;   // root bits, one per stage
  localparam int DIV_STEPS = 17;   // quotient bits, one per stage
  localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;
  // input reg + two normalizers + cross + final dot stages
  localparam int PIPE_LAT  = 1 + NORM_LAT + 2 + NORM_LAT + 6;

  typedef logic signed [NW-1:0] nin_t;
  typedef logic signed [OW-1:0] nout_t;
  typedef logic signed [31:0]   q_t;

  typedef struct packed {
    q_t cam_x;
    q_t cam_y;
    q_t cam_z;
    q_t target_x;
    q_t target_y;
    q_t target_z;
    q_t up_x;
    q_t up_y;
    q_t up_z;
  } vec_t;

  typedef struct packed {
    q_t m00;
    q_t m01;
    q_t m02;
    q_t m03;
    q_t m10;
    q_t m11;
    q_t m12;
    q_t m13;
    q_t m20;
    q_t m21;
    q_t m22;
    q_t m23;
  } mat_t;

  localparam logic signed [40:0] SAT_HI = 41'sd2147483647;
  localparam logic signed [40:0] SAT_LO = -41'sd2147483648;

  // Round Q32.32 to Q16.16, half away from zero
  function automatic logic signed [40:0] round16(input logic signed [55:0] x);
    logic [55:0] mg;
    logic [39:0] r;
    mg = x[55] ? 56'(-x) : 56'(x);
    r  = 40'((mg + 56'd32768) >> 16);
    round16 = x[55] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic q_t sat32(input logic signed [40:0] x);
    if (x > SAT_HI) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// File: hdl/lav_norm.sv
module lav_norm (
  input  logic          clk,
  input  logic          en,
  input  lav_pkg::nin_t v [3],
  output lav_pkg::nout_t o [3]
);
  import lav_pkg::*;

  localparam int SH_T = MW - 1;
  localparam int NUMW = MW + 17;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  logic [NW-1:0]     m1 [3];
  logic [NW-1:0]     top1;
  side_t             side1;
  logic [5:0]        p2;
  logic [NW-1:0]     m2 [3];
  logic [MW-1:0]     m3 [3];
  logic [2*MW-1:0]   sq4 [3];
  logic [MW-1:0]     m4 [3];
  side_t             sd [NORM_LAT-2];

  logic [2*MW+1:0]   sq_n    [SQ_STEPS+1];
  logic [32:0]       sq_rem  [SQ_STEPS+1];
  logic [30:0]       sq_root [SQ_STEPS+1];
  logic [MW-1:0]     sq_m    [SQ_STEPS+1][3];
  logic [2*MW+1:0]   sq_n_next    [SQ_STEPS];
  logic [32:0]       sq_rem_next  [SQ_STEPS];
  logic [30:0]       sq_root_next [SQ_STEPS];

  logic [NUMW-1:0]   dv_rem [DIV_STEPS+1][3];
  logic [30:0]       dv_d   [DIV_STEPS+1];
  logic [16:0]       dv_q   [DIV_STEPS+1][3];
  logic [NUMW-1:0]   dv_rem_next [DIV_STEPS][3];
  logic [16:0]       dv_q_next   [DIV_STEPS][3];

  logic [NW-1:0]     mag_c [3];
  logic [NW-1:0]     top_c;
  logic [5:0]        p_c;
  logic [MW-1:0]     sh_c [3];

  // Magnitudes and largest magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v[i][NW-1] ? NW'(-v[i]) : NW'(v[i]);
    end
    top_c = mag_c[0];
    if (mag_c[1] > top_c) top_c = mag_c[1];
    if (mag_c[2] > top_c) top_c = mag_c[2];
  end

  // Leading one position of the largest magnitude
  always_comb begin
    p_c = '0;
    for (int b = 0; b < NW; b++) begin
      if (top1[b]) p_c = 6'(b);
    end
  end

  // Scale so the largest magnitude lands in [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2 >= 6'(SH_T)) begin
        sh_c[i] = MW'(m2[i] >> (p2 - 6'(SH_T)));
      end else begin
        sh_c[i] = MW'(m2[i] << (6'(SH_T) - p2));
      end
    end
  end

  // Square root, one root bit per stage
  always_comb begin
    logic [34:0] rs;
    logic [34:0] tr;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rs = {sq_rem[i], sq_n[i][2*MW+1 -: 2]};
      tr = {2'b00, sq_root[i], 2'b01};
      if (rs >= tr) begin
        sq_rem_next[i]  = 33'(rs - tr);
        sq_root_next[i] = {sq_root[i][29:0], 1'b1};
      end else begin
        sq_rem_next[i]  = rs[32:0];
        sq_root_next[i] = {sq_root[i][29:0], 1'b0};
      end
      sq_n_next[i] = {sq_n[i][2*MW-1:0], 2'b00};
    end
  end

  // Restoring division, one quotient bit per stage
  always_comb begin
    logic [NUMW:0] trial;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = (NUMW+1)'({17'd0, dv_d[i]}) << (DIV_STEPS - 1 - i);
      for (int j = 0; j < 3; j++) begin
        if ({1'b0, dv_rem[i][j]} >= trial) begin
          dv_rem_next[i][j] = NUMW'({1'b0, dv_rem[i][j]} - trial);
          dv_q_next[i][j]   = {dv_q[i][j][15:0], 1'b1};
        end else begin
          dv_rem_next[i][j] = dv_rem[i][j];
          dv_q_next[i][j]   = {dv_q[i][j][15:0], 1'b0};
        end
      end
    end
  end

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= mag_c;
      top1  <= top_c;
      for (int i = 0; i < 3; i++) side1.neg[i] <= v[i][NW-1];
      side1.zero <= (top_c == '0);
      p2    <= p_c;
      m2    <= m1;
      m3    <= sh_c;
      for (int i = 0; i < 3; i++) sq4[i] <= m3[i] * m3[i];
      m4    <= m3;
      sd[0] <= side1;
      for (int i = 1; i < NORM_LAT-2; i++) sd[i] <= sd[i-1];

      sq_n[0]    <= (2*MW+2)'(sq4[0]) + (2*MW+2)'(sq4[1]) + (2*MW+2)'(sq4[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_m[0]    <= m4;
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_n[i+1]    <= sq_n_next[i];
        sq_rem[i+1]  <= sq_rem_next[i];
        sq_root[i+1] <= sq_root_next[i];
        sq_m[i+1]    <= sq_m[i];
      end

      dv_d[0] <= sq_root[SQ_STEPS];
      for (int j = 0; j < 3; j++) begin
        dv_rem[0][j] <= {1'b0, sq_m[SQ_STEPS][j], 16'd0}
                        + NUMW'(sq_root[SQ_STEPS][30:1]);
        dv_q[0][j]   <= '0;
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        dv_d[i+1]   <= dv_d[i];
        dv_rem[i+1] <= dv_rem_next[i];
        dv_q[i+1]   <= dv_q_next[i];
      end

      for (int j = 0; j < 3; j++) begin
        if (sd[NORM_LAT-3].zero) begin
          o[j] <= '0;
        end else if (sd[NORM_LAT-3].neg[j]) begin
          o[j] <= -$signed({1'b0, dv_q[DIV_STEPS][j]});
        end else begin
          o[j] <= $signed({1'b0, dv_q[DIV_STEPS][j]});
        end
      end
    end
  end

endmodule

// File: hdl/look_at_view_matrix.sv
// Throughput: one beat per cycle while the skid buffer is empty; the depth of the pipe
// from an accepted beat to its result beat comes from two normalizers in series,
// each a 31-stage square root and a 17-stage divider, one bit per stage.
// A one-entry skid buffer at the output lets the pipe drain one beat under stall.
// Reset (synchronous, active high) clears the valid bits and the skid buffer.
module look_at_view_matrix (
  input  logic          clk,
  input  logic          rst,
  input  logic          vec_valid,
  output logic          vec_stall,
  input  lav_pkg::vec_t vec,
  output logic          mat_valid,
  input  logic          mat_stall,
  output lav_pkg::mat_t mat
);
  import lav_pkg::*;

  logic          en;
  logic          vld [PIPE_LAT];
  logic          skid_valid;
  mat_t          skid;
  mat_t          mat_r;

  // Stage: input register
  logic signed [32:0] dif1 [3];
  q_t                 up1  [3];
  q_t                 cam1 [3];
  nin_t               n1_in [3];
  nin_t               n2_in [3];
  nout_t              f_o [3];
  nout_t              u_o [3];
  q_t                 cam_d [NORM_LAT][3];

  // Cross f x u
  logic signed [35:0] pfu [6];
  nin_t               raw [3];
  nout_t              s_o [3];
  nout_t              fd [NORM_LAT+2][3];
  q_t                 cd [NORM_LAT+2][3];

  // Tail stages
  logic signed [35:0] psf [6];
  logic signed [49:0] psc [3];
  logic signed [49:0] pfc [3];
  nout_t              s5 [3], s6 [3], s7 [3], s8 [3], s9 [3];
  nout_t              f5 [3], f6 [3], f7 [3], f8 [3], f9 [3];
  q_t                 c5 [3], c6 [3], c7 [3];
  logic signed [35:0] traw [3];
  logic signed [51:0] scs;
  logic signed [51:0] fcs;
  logic signed [18:0] t7 [3], t8 [3], t9 [3];
  q_t                 m03_7, m03_8, m03_9;
  q_t                 m23_7, m23_8, m23_9;
  logic signed [50:0] ptc [3];
  logic signed [52:0] tcs;
  logic signed [40:0] rt [3];

  assign en        = !skid_valid;
  assign vec_stall = skid_valid;
  assign mat_valid = skid_valid | vld[PIPE_LAT-1];
  assign mat       = skid_valid ? skid : mat_r;

  // Hold one result beat when the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!mat_stall) skid_valid <= 1'b0;
    end else if (vld[PIPE_LAT-1] && mat_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vld[PIPE_LAT-1] && mat_stall) skid <= mat_r;
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= vec_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_in[i] = NW'(dif1[i]);
      n2_in[i] = NW'(up1[i]);
    end
  end

  lav_norm u_norm_f (.clk(clk), .en(en), .v(n1_in), .o(f_o));
  lav_norm u_norm_u (.clk(clk), .en(en), .v(n2_in), .o(u_o));
  lav_norm u_norm_s (.clk(clk), .en(en), .v(raw),   .o(s_o));

  // Rounded t components for the last dot product
  always_comb begin
    for (int i = 0; i < 3; i++) rt[i] = round16(56'(traw[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Register camera and up, form target minus camera
      cam1[0] <= vec.cam_x;
      cam1[1] <= vec.cam_y;
      cam1[2] <= vec.cam_z;
      up1[0]  <= vec.up_x;
      up1[1]  <= vec.up_y;
      up1[2]  <= vec.up_z;
      dif1[0] <= 33'(vec.target_x) - 33'(vec.cam_x);
      dif1[1] <= 33'(vec.target_y) - 33'(vec.cam_y);
      dif1[2] <= 33'(vec.target_z) - 33'(vec.cam_z);

      cam_d[0] <= cam1;
      for (int i = 1; i < NORM_LAT; i++) cam_d[i] <= cam_d[i-1];

      // Cross f x u: products, then differences
      pfu[0] <= f_o[1] * u_o[2];
      pfu[1] <= f_o[2] * u_o[1];
      pfu[2] <= f_o[2] * u_o[0];
      pfu[3] <= f_o[0] * u_o[2];
      pfu[4] <= f_o[0] * u_o[1];
      pfu[5] <= f_o[1] * u_o[0];
      raw[0] <= pfu[0] - pfu[1];
      raw[1] <= pfu[2] - pfu[3];
      raw[2] <= pfu[4] - pfu[5];

      // Carry f and camera to meet s
      fd[0] <= f_o;
      cd[0] <= cam_d[NORM_LAT-1];
      for (int i = 1; i < NORM_LAT+2; i++) begin
        fd[i] <= fd[i-1];
        cd[i] <= cd[i-1];
      end

      // Products for s x f, s.cam and f.cam
      psf[0] <= s_o[1] * fd[NORM_LAT+1][2];
      psf[1] <= s_o[2] * fd[NORM_LAT+1][1];
      psf[2] <= s_o[2] * fd[NORM_LAT+1][0];
      psf[3] <= s_o[0] * fd[NORM_LAT+1][2];
      psf[4] <= s_o[0] * fd[NORM_LAT+1][1];
      psf[5] <= s_o[1] * fd[NORM_LAT+1][0];
      for (int i = 0; i < 3; i++) begin
        psc[i] <= s_o[i] * cd[NORM_LAT+1][i];
        pfc[i] <= fd[NORM_LAT+1][i] * cd[NORM_LAT+1][i];
      end
      s5 <= s_o;
      f5 <= fd[NORM_LAT+1];
      c5 <= cd[NORM_LAT+1];

      // Sums
      traw[0] <= psf[0] - psf[1];
      traw[1] <= psf[2] - psf[3];
      traw[2] <= psf[4] - psf[5];
      scs <= 52'(psc[0]) + 52'(psc[1]) + 52'(psc[2]);
      fcs <= 52'(pfc[0]) + 52'(pfc[1]) + 52'(pfc[2]);
      s6 <= s5;
      f6 <= f5;
      c6 <= c5;

      // Round t, finish side and forward translations
      for (int i = 0; i < 3; i++) t7[i] <= rt[i][18:0];
      m03_7 <= sat32(-round16(56'(scs)));
      m23_7 <= sat32(round16(56'(fcs)));
      s7 <= s6;
      f7 <= f6;
      c7 <= c6;

      // t.cam products
      for (int i = 0; i < 3; i++) ptc[i] <= t7[i] * c7[i];
      t8 <= t7;
      s8 <= s7;
      f8 <= f7;
      m03_8 <= m03_7;
      m23_8 <= m23_7;

      tcs <= 53'(ptc[0]) + 53'(ptc[1]) + 53'(ptc[2]);
      t9 <= t8;
      s9 <= s8;
      f9 <= f8;
      m03_9 <= m03_8;
      m23_9 <= m23_8;

      // Assemble the result beat
      mat_r.m00 <= 32'(s9[0]);
      mat_r.m01 <= 32'(s9[1]);
      mat_r.m02 <= 32'(s9[2]);
      mat_r.m03 <= m03_9;
      mat_r.m10 <= 32'(t9[0]);
      mat_r.m11 <= 32'(t9[1]);
      mat_r.m12 <= 32'(t9[2]);
      mat_r.m13 <= sat32(-round16(56'(tcs)));
      mat_r.m20 <= -32'(f9[0]);
      mat_r.m21 <= -32'(f9[1]);
      mat_r.m22 <= -32'(f9[2]);
      mat_r.m23 <= m23_9;
    end
  end

`ifndef SYNTHESIS
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && vld[PIPE_LAT-1] && mat_stall) |=> skid_valid)
    else $error("result beat not caught in skid buffer");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !mat_stall) |=> !skid_valid)
    else $error("skid buffer not drained after delivery");
  a_skid_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> (vld[PIPE_LAT-1] == $past(vld[PIPE_LAT-1])))
    else $error("pipeline advanced while skid buffer full");
`endif

endmodule

// File: tb/look_at_view_matrix_test.sv
`timescale 1ns / 1ps

module look_at_view_matrix_test;
  import lav_pkg::*;

  typedef longint trio_t [3];

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 160;

  logic  clk;
  logic  rst;
  logic  vec_valid;
  logic  vec_stall;
  vec_t  vec;
  logic  mat_valid;
  logic  mat_stall;
  mat_t  mat;

  mat_t  pending_mats[$];
  bit    failed;
  bit    no_idle;
  int    quiet_cycles;

  look_at_view_matrix uut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to a unit vector in Q16.16; zero stays zero
  function automatic trio_t unit_vec(input trio_t v);
    longint unsigned mg[3];
    longint unsigned top, sum, len, qt;
    trio_t o;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = v[i] < 0 ? -v[i] : v[i];
      if (mg[i] > top) top = mg[i];
    end
    if (top == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    while (top >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      qt = (mg[i] * 64'd65536 + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(qt) : longint'(qt);
    end
    return o;
  endfunction

  function automatic trio_t cross_vec(input trio_t a, input trio_t b);
    trio_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  // Q32.32 to Q16.16, half away from zero
  function automatic longint to_q16(input longint x);
    longint unsigned mg;
    mg = ((x < 0 ? -x : x) + 64'd32768) >> 16;
    return x < 0 ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic q_t clamp_q32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return q_t'(x);
  endfunction

  function automatic longint dot_q16(input trio_t a, input trio_t c);
    return to_q16(a[0] * c[0] + a[1] * c[1] + a[2] * c[2]);
  endfunction

  // Build the expected view matrix rows for one beat
  function automatic mat_t view_rows(input vec_t v);
    trio_t cam, dif, upv, fwd, upn, side, tup;
    mat_t r;
    cam = '{longint'(v.cam_x), longint'(v.cam_y), longint'(v.cam_z)};
    dif = '{longint'(v.target_x) - cam[0], longint'(v.target_y) - cam[1],
            longint'(v.target_z) - cam[2]};
    upv = '{longint'(v.up_x), longint'(v.up_y), longint'(v.up_z)};
    fwd  = unit_vec(dif);
    upn  = unit_vec(upv);
    side = unit_vec(cross_vec(fwd, upn));
    tup  = cross_vec(side, fwd);
    for (int i = 0; i < 3; i++) tup[i] = to_q16(tup[i]);
    r.m00 = q_t'(side[0]); r.m01 = q_t'(side[1]); r.m02 = q_t'(side[2]);
    r.m03 = clamp_q32(-dot_q16(side, cam));
    r.m10 = q_t'(tup[0]);  r.m11 = q_t'(tup[1]);  r.m12 = q_t'(tup[2]);
    r.m13 = clamp_q32(-dot_q16(tup, cam));
    r.m20 = q_t'(-fwd[0]); r.m21 = q_t'(-fwd[1]); r.m22 = q_t'(-fwd[2]);
    r.m23 = clamp_q32(dot_q16(fwd, cam));
    return r;
  endfunction

  // Send one beat after a random gap; record its matrix at acceptance
  task automatic send_vec(input vec_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec <= v;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    pending_mats.push_back(view_rows(v));
  endtask

  function automatic vec_t make_vec(input q_t cx, cy, cz, tx, ty, tz, ux, uy, uz);
    vec_t v;
    v = '{cx, cy, cz, tx, ty, tz, ux, uy, uz};
    return v;
  endfunction

  function automatic q_t rand_q(input int kind);
    case (kind)
      0: return q_t'($urandom);
      1: return q_t'(int'($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
      default: return q_t'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  task automatic test_degenerate();
    // zero everything, target on camera, zero up, up along and against forward
    send_vec(make_vec(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_vec(make_vec(32'sh10000, 5, -7, 32'sh10000, 5, -7, 0, 32'sh10000, 0));
    send_vec(make_vec(1, 2, 3, 32'sh50000, 2, 3, 0, 0, 0));
    send_vec(make_vec(0, 0, 0, 0, 0, 32'sh30000, 0, 0, 32'sh10000));
    send_vec(make_vec(0, 0, 0, 0, 0, 32'sh30000, 0, 0, -32'sh20000));
    send_vec(make_vec(0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0));
  endtask

  task automatic test_directed();
    q_t mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_vec(make_vec(0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0));
    send_vec(make_vec(32'sh30000, -32'sh20000, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 0));
    send_vec(make_vec(mx, mx, mx, mn, mn, mn, 0, 32'sh10000, 0));
    send_vec(make_vec(mn, mn, mn, mx, mx, mx, mx, mn, 1));
    send_vec(make_vec(mn, mx, mn, mx, mn, mx, mn, mn, mn));
    send_vec(make_vec(mx, mn, 0, mx, mn, 1, mx, mx, mx));
    send_vec(make_vec(1, -1, 1, -1, 1, -1, -1, -1, -1));
    // translations past full scale
    send_vec(make_vec(mn, mn, mn, mn + 100, mn + 100, mn + 100, 0, 32'sh10000, 0));
    send_vec(make_vec(mx, mx, mx, mx - 100, mx - 100, mx - 100, 32'sh10000, 0, 0));
    send_vec(make_vec(mx, mn, mx, 0, 0, 0, 0, 0, 32'sh10000));
  endtask

  task automatic test_random(input int count);
    vec_t v;
    int kc, kt, ku, sh;
    for (int n = 0; n < count; n++) begin
      kc = $urandom_range(0, 2);
      kt = $urandom_range(0, 2);
      ku = $urandom_range(0, 2);
      v = make_vec(rand_q(kc), rand_q(kc), rand_q(kc), rand_q(kt), rand_q(kt),
                   rand_q(kt), rand_q(ku), rand_q(ku), rand_q(ku));
      sh = $urandom_range(0, 19);
      if (sh == 0) begin
        v.target_x = v.cam_x; v.target_y = v.cam_y; v.target_z = v.cam_z;
      end else if (sh == 1) begin
        v.up_x = 0; v.up_y = 0; v.up_z = 0;
      end else if (sh == 2) begin
        // up along the view direction
        v.cam_x = rand_q(2); v.cam_y = rand_q(2); v.cam_z = rand_q(2);
        v.up_x = 3 * (v.up_x / 65536); v.up_y = 3 * (v.up_y / 65536);
        v.up_z = 3 * (v.up_z / 65536);
        v.target_x = v.cam_x + v.up_x;
        v.target_y = v.cam_y + v.up_y;
        v.target_z = v.cam_z + v.up_z;
      end
      send_vec(v);
    end
  endtask

  // Hold off sending until every matrix has come back, then send 40 random beats
  task automatic test_drain_pause();
    vec_valid <= 1'b0;
    @(posedge clk);
    while (pending_mats.size() != 0) @(posedge clk);
    test_random(40);
  endtask

  // Receiver stall: random hold before each beat
  initial begin
    int hold;
    mat_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        mat_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      mat_stall <= 1'b0;
      @(posedge clk);
      while (!mat_valid) @(posedge clk);
    end
  end

  // Compare each accepted matrix with the oldest expectation
  always @(posedge clk) begin
    logic [11:0][31:0] want, got;
    if (!rst && mat_valid && !mat_stall) begin
      if (pending_mats.size() == 0) begin
        $display("%0t: unexpected matrix beat %h", $time, mat);
        failed = 1'b1;
      end else begin
        want = pending_mats.pop_front();
        got = mat;
        for (int i = 11; i >= 0; i--) begin
          if (want[i] !== got[i]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, (11 - i) / 4,
                     (11 - i) % 4, want[i], got[i]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat while work is outstanding
  always @(posedge clk) begin
    if (rst || (vec_valid && !vec_stall) || (mat_valid && !mat_stall)) begin
      quiet_cycles <= 0;
    end else if (vec_valid || pending_mats.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL look_at_view_matrix");
        $finish;
      end
    end
  end

  initial begin
    no_idle = 1'b0;
    rst = 1'b1;
    vec_valid = 1'b0;
    vec = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_directed();
    test_random(500);
    test_drain_pause();
    no_idle = 1'b1;
    test_random(200);
    no_idle = 1'b0;
    test_random(340);
    vec_valid <= 1'b0;
    @(posedge clk);
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_mats.size() == 0) begin
      $display("PASS look_at_view_matrix");
    end else begin
      $display("FAIL look_at_view_matrix");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/look_at_view_matrix.sv
tb/look_at_view_matrix_test.sv
